@@ rtl/siphash_keyed_mac_macros.svh @@
// Assertion macros shared by the RTL.
// SHK_ASSERT_IMPLY: same-cycle implication.  SHK_ASSERT_NEXT: next-cycle implication.
`ifndef SIPHASH_KEYED_MAC_MACROS_SVH
`define SIPHASH_KEYED_MAC_MACROS_SVH

`ifndef SYNTHESIS
`define SHK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SHK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SHK_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SHK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/shk_pkg.sv @@
`default_nettype none
package shk_pkg;

   localparam logic [63:0] SIP_C0        = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1        = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2        = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3        = 64'h7465646279746573;
   localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes, paddr[4:3]
   typedef enum logic [1:0] {
      CSR_KEY_LOW   = 2'd0,
      CSR_KEY_HIGH  = 2'd1,
      CSR_CMP_ROUND = 2'd2,
      CSR_FIN_ROUND = 2'd3
   } shk_csr_type;

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } shk_lanes_type;

   // one padded block for the back end
   typedef struct packed {
      logic [63:0] block;
      logic        is_start;  // reload lanes from key first
      logic        is_final;  // finalise after absorbing
   } shk_entry_type;

   function automatic shk_lanes_type sip_round(input shk_lanes_type v);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
      shk_lanes_type r;
      a = v.v0;
      b = v.v1;
      c = v.v2;
      d = v.v3;
      a = a + b;  b = {b[50:0], b[63:51]};  b = b ^ a;  a = {a[31:0], a[63:32]};
      c = c + d;  d = {d[47:0], d[63:48]};  d = d ^ c;
      a = a + d;  d = {d[42:0], d[63:43]};  d = d ^ a;
      c = c + b;  b = {b[46:0], b[63:47]};  b = b ^ c;  c = {c[31:0], c[63:32]};
      r.v0 = a;
      r.v1 = b;
      r.v2 = c;
      r.v3 = d;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/shk_front.sv @@
`default_nettype none
module shk_front
   import shk_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   word,
   input  wire logic [3:0]    byte_count,
   input  wire logic          last_word,
   input  wire logic          queue_full,
   output logic               push,
   output shk_entry_type      push_entry
);

   logic        open_ff, open_in;
   logic [7:0]  len_ff, len_in;
   logic        pend_ff, pend_in;
   logic [63:0] pend_blk_ff, pend_blk_in;

   logic [3:0]  cnt_sat;
   logic [7:0]  len_base;
   logic [7:0]  len_next;
   logic [63:0] mask;
   logic        accept;

   assign req_tready = !pend_ff && !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign cnt_sat    = (byte_count > 4'd8) ? 4'd8 : byte_count;
   assign len_base   = open_ff ? len_ff : 8'd0;
   assign mask       = (64'd1 << {cnt_sat[2:0], 3'b000}) - 64'd1;

   always_comb begin
      open_in     = open_ff;
      len_in      = len_ff;
      pend_in     = pend_ff;
      pend_blk_in = pend_blk_ff;
      push        = 1'b0;
      push_entry  = '{block: word, is_start: !open_ff, is_final: 1'b0};
      len_next    = len_base + 8'd8;
      if (pend_ff) begin
         // length-only block after a full last word
         push_entry = '{block: pend_blk_ff, is_start: 1'b0, is_final: 1'b1};
         if (!queue_full) begin
            push    = 1'b1;
            pend_in = 1'b0;
         end
      end else if (accept) begin
         push = 1'b1;
         if (!last_word) begin
            open_in = 1'b1;
            len_in  = len_next;
         end else if (cnt_sat == 4'd8) begin
            open_in     = 1'b0;
            len_in      = len_next;
            pend_in     = 1'b1;
            pend_blk_in = {len_next, 56'd0};
         end else begin
            len_next   = len_base + {5'd0, cnt_sat[2:0]};
            open_in    = 1'b0;
            len_in     = len_next;
            push_entry = '{block: (word & mask) | {len_next, 56'd0},
                           is_start: !open_ff, is_final: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         len_ff  <= 8'd0;
         pend_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
         len_ff  <= len_in;
         pend_ff <= pend_in;
      end
      pend_blk_ff <= pend_blk_in;
   end

endmodule
`default_nettype wire

@@ rtl/shk_queue.sv @@
`default_nettype none
`include "siphash_keyed_mac_macros.svh"
module shk_queue
   import shk_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire shk_entry_type push_entry,
   output logic               full,
   input  wire logic          pop,
   output shk_entry_type      head,
   output logic               head_valid
);

   shk_entry_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SHK_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full || pop)
   `SHK_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, head_valid)
   `SHK_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))

endmodule
`default_nettype wire

@@ rtl/shk_back.sv @@
`default_nettype none
`include "siphash_keyed_mac_macros.svh"
module shk_back
   import shk_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [63:0]   key_low,
   input  wire logic [63:0]   key_high,
   input  wire logic [2:0]    compression_rounds,
   input  wire logic [3:0]    final_rounds,
   input  wire shk_entry_type head,
   input  wire logic          head_valid,
   output logic               pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [63:0]        rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_ABSORB = 3'b010,
      S_FINAL  = 3'b100
   } shk_state_type;

   shk_state_type state_ff, state_in;
   shk_lanes_type lanes_ff, lanes_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [63:0]   blk_ff, blk_in;
   logic          fin_ff, fin_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   hash_ff, hash_in;

   shk_lanes_type init_lanes;
   shk_lanes_type round_v;
   shk_lanes_type done;
   logic          out_free;

   assign init_lanes = '{v0: SIP_C0 ^ key_low,  v1: SIP_C1 ^ key_high,
                         v2: SIP_C2 ^ key_low,  v3: SIP_C3 ^ key_high};
   assign round_v    = sip_round(lanes_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = hash_ff;

   always_comb begin
      state_in     = state_ff;
      lanes_in     = lanes_ff;
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      fin_in       = fin_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      done         = (cnt_ff == 4'd0) ? lanes_ff : round_v;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop         = 1'b1;
               lanes_in    = head.is_start ? init_lanes : lanes_ff;
               lanes_in.v3 = lanes_in.v3 ^ head.block;
               blk_in      = head.block;
               fin_in      = head.is_final;
               cnt_in      = {1'b0, compression_rounds};
               state_in    = S_ABSORB;
            end
         end
         S_ABSORB: begin
            if (cnt_ff > 4'd1) begin
               lanes_in = round_v;
               cnt_in   = cnt_ff - 4'd1;
            end else begin
               // last round of the block closes it, and may open the next
               done.v0 = done.v0 ^ blk_ff;
               if (fin_ff) begin
                  done.v2  = done.v2 ^ SIP_FINAL_XOR;
                  cnt_in   = final_rounds;
                  state_in = S_FINAL;
               end else if (head_valid) begin
                  pop     = 1'b1;
                  done.v3 = done.v3 ^ head.block;
                  blk_in  = head.block;
                  fin_in  = head.is_final;
                  cnt_in  = {1'b0, compression_rounds};
               end else begin
                  state_in = S_IDLE;
               end
               lanes_in = done;
            end
         end
         S_FINAL: begin
            if (cnt_ff > 4'd1) begin
               lanes_in = round_v;
               cnt_in   = cnt_ff - 4'd1;
            end else if (out_free) begin
               lanes_in     = done;
               hash_in      = done.v0 ^ done.v1 ^ done.v2 ^ done.v3;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lanes_ff <= lanes_in;
      blk_ff   <= blk_in;
      fin_ff   <= fin_in;
      hash_ff  <= hash_in;
   end

   `SHK_ASSERT_NEXT(a_tag_waits, clock, reset, (state_ff == S_FINAL) && (cnt_ff <= 4'd1) && !out_free, state_ff == S_FINAL)
   `SHK_ASSERT_NEXT(a_tag_issued, clock, reset, (state_ff == S_FINAL) && (cnt_ff <= 4'd1) && out_free, rsp_valid_ff && (state_ff == S_IDLE))
   `SHK_ASSERT_IMPLY(a_pop_in_work, clock, reset, pop, head_valid && (state_ff != S_FINAL))

endmodule
`default_nettype wire

@@ rtl/siphash_keyed_mac.sv @@
`default_nettype none
// Channel  Direction  Beat contents                                   Accepted when
// req_     in         tdata: message_word, byte_count; tlast: last    req_tvalid & req_tready
// rsp_     out        tdata: hash_value                               rsp_tvalid & rsp_tready
// csr_     in         APB write of key_low/key_high/rounds, 8*i       psel & penable & pwrite
//
// One SipRound per cycle while no held tag stalls the rounds; each block gets c rounds,
// c = compression rounds, and the tag d more after its last block, d = final rounds.
// SipHash-2-4 by default; a full last word adds a length-only block after it.
// Synchronous active-high reset: key 0, rounds 2 and 4, no message open.
// Two-entry block queue between front and rounds; a held tag stalls the rounds, then req_tready.
module siphash_keyed_mac
   import shk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // [63:0] message_word, [67:64] byte_count, [71:68] 0
   input  wire logic        req_tlast,   // last_word
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [63:0] hash_value
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [2:0]  cmp_rounds_ff;
   logic [3:0]  fin_rounds_ff;

   logic          csr_wr;
   shk_csr_type   csr_idx;

   logic          push;
   shk_entry_type push_entry;
   logic          queue_full;
   logic          pop;
   shk_entry_type head;
   logic          head_valid;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = shk_csr_type'(csr_paddr[4:3]);

   // the user must let registers change only between messages; not enforced here, hence no shadow copies
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= 64'd0;
         key_high_ff   <= 64'd0;
         cmp_rounds_ff <= 3'd2;
         fin_rounds_ff <= 4'd4;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_KEY_LOW:   key_low_ff    <= csr_pwdata;
            CSR_KEY_HIGH:  key_high_ff   <= csr_pwdata;
            CSR_CMP_ROUND: cmp_rounds_ff <= csr_pwdata[2:0];
            CSR_FIN_ROUND: fin_rounds_ff <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_KEY_LOW:   csr_prdata = key_low_ff;
         CSR_KEY_HIGH:  csr_prdata = key_high_ff;
         CSR_CMP_ROUND: csr_prdata = {61'd0, cmp_rounds_ff};
         CSR_FIN_ROUND: csr_prdata = {60'd0, fin_rounds_ff};
         default:       csr_prdata = 64'd0;
      endcase
   end

   // front: tracks length and message start, pads the last word
   shk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .word       (req_tdata[63:0]),
      .byte_count (req_tdata[67:64]),
      .last_word  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   shk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // back: lanes, round unit, finalisation and tag register
   shk_back u_back (
      .clock              (clock),
      .reset              (reset),
      .key_low            (key_low_ff),
      .key_high           (key_high_ff),
      .compression_rounds (cmp_rounds_ff),
      .final_rounds       (fin_rounds_ff),
      .head               (head),
      .head_valid         (head_valid),
      .pop                (pop),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata)
   );

endmodule
`default_nettype wire

@@ verif/siphash_tag_checker.sv @@
`timescale 1ns / 1ps
// Watches all three ports, keeps its own copy of the lanes and registers,
// predicts each tag and checks the result beats in order.
module siphash_tag_checker
   import shk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,    // [63:0] message_word, [67:64] byte_count, [71:68] 0
   input  logic        req_tlast,    // last_word
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,    // [63:0] hash_value
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending,
   output int          tags_checked
);

   logic [63:0]   key_lo;
   logic [63:0]   key_hi;
   logic [2:0]    cmp_rounds;
   logic [3:0]    fin_rounds;
   shk_lanes_type lanes;
   logic [7:0]    msg_len;
   logic          in_message;
   logic [63:0]   expected_tags[$];
   int            error_count;
   int            compared;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic shk_lanes_type sip_mix(input shk_lanes_type s);
      s.v0 = s.v0 + s.v1;  s.v1 = rotl(s.v1, 13);  s.v1 ^= s.v0;  s.v0 = rotl(s.v0, 32);
      s.v2 = s.v2 + s.v3;  s.v3 = rotl(s.v3, 16);  s.v3 ^= s.v2;
      s.v0 = s.v0 + s.v3;  s.v3 = rotl(s.v3, 21);  s.v3 ^= s.v0;
      s.v2 = s.v2 + s.v1;  s.v1 = rotl(s.v1, 17);  s.v1 ^= s.v2;  s.v2 = rotl(s.v2, 32);
      return s;
   endfunction

   function automatic shk_lanes_type mix_rounds(input shk_lanes_type s, input int n);
      for (int i = 0; i < n; i++)
         s = sip_mix(s);
      return s;
   endfunction

   function automatic shk_lanes_type absorb_block(input shk_lanes_type s,
                                                  input logic [63:0] m, input int n);
      s.v3 ^= m;
      s = mix_rounds(s, n);
      s.v0 ^= m;
      return s;
   endfunction

   always @(posedge clock) begin : watch
      logic [63:0] word;
      logic [63:0] blk;
      logic [63:0] want;
      int          cnt;
      if (reset) begin
         key_lo      = '0;
         key_hi      = '0;
         cmp_rounds  = 3'd2;
         fin_rounds  = 4'd4;
         msg_len     = '0;
         in_message  = 1'b0;
         expected_tags.delete();
         error_count = 0;
         compared    = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (shk_csr_type'(csr_paddr[4:3]))
               CSR_KEY_LOW:   key_lo = csr_pwdata;
               CSR_KEY_HIGH:  key_hi = csr_pwdata;
               CSR_CMP_ROUND: cmp_rounds = csr_pwdata[2:0];
               CSR_FIN_ROUND: fin_rounds = csr_pwdata[3:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            word = req_tdata[63:0];
            cnt  = int'(req_tdata[67:64]);
            // lanes take the key as it stands when a message opens
            if (!in_message) begin
               lanes.v0   = SIP_C0 ^ key_lo;
               lanes.v1   = SIP_C1 ^ key_hi;
               lanes.v2   = SIP_C2 ^ key_lo;
               lanes.v3   = SIP_C3 ^ key_hi;
               msg_len    = '0;
               in_message = 1'b1;
            end
            if (!req_tlast) begin
               lanes   = absorb_block(lanes, word, int'(cmp_rounds));
               msg_len = msg_len + 8'd8;
            end else begin
               if (cnt > 8)
                  cnt = 8;
               if (cnt == 8) begin
                  // full last word, then a block with only the length
                  lanes   = absorb_block(lanes, word, int'(cmp_rounds));
                  msg_len = msg_len + 8'd8;
                  blk     = '0;
               end else begin
                  blk     = (cnt == 0) ? 64'd0 : word & ((64'd1 << (8 * cnt)) - 64'd1);
                  msg_len = msg_len + 8'(cnt);
               end
               blk[63:56] = blk[63:56] | msg_len;
               lanes      = absorb_block(lanes, blk, int'(cmp_rounds));
               lanes.v2   = lanes.v2 ^ SIP_FINAL_XOR;
               lanes      = mix_rounds(lanes, int'(fin_rounds));
               expected_tags.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
               in_message = 1'b0;
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            if (expected_tags.size() == 0) begin
               if (error_count < 10)
                  $display("%t: tag beat %h with nothing expected", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_tags.pop_front();
               compared++;
               if (rsp_tdata !== want) begin
                  if (error_count < 10)
                     $display("%t: hash_value expected %h, got %h", $time, want, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
      failures     <= error_count;
      pending      <= expected_tags.size();
      tags_checked <= compared;
   end

endmodule

@@ verif/tb_siphash_keyed_mac.sv @@
`timescale 1ns / 1ps
module tb_siphash_keyed_mac;
   import shk_pkg::*;

   // cycles to let the round unit finish after the last tag, enough for a full last
   // word at 7 compression and 15 final rounds plus two queued blocks
   localparam int SETTLE      = 64;
   // receiver hold-off, long enough to back up the block queue and the tag
   localparam int HOLD_CYCLES = 400;
   // random beats per register setting
   localparam int PHASE_BEATS = 315;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;     // [63:0] message_word, [67:64] byte_count, [71:68] 0
   logic        req_tlast;     // last_word
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;     // [63:0] hash_value
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int pending;
   int tags_checked;

   // stimulus bookkeeping
   int   burst_left    = 0;
   int   beats_sent    = 0;
   int   messages_sent = 0;
   int   settings_run  = 0;
   logic hold_request  = 1'b0;   // set by stimulus, consumed by the receiver

   always #5 clock = ~clock;

   siphash_keyed_mac uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   siphash_tag_checker tag_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .failures     (failures),
      .pending      (pending),
      .tags_checked (tags_checked)
   );

   // --------------------------------------------------------------------------
   // Sender helpers. Everything is driven at the falling edge; handshakes are
   // seen at the rising edge.
   // --------------------------------------------------------------------------

   // One request beat. Beats go out in bursts of random length; between bursts
   // valid drops for a random gap, and some bursts follow straight on.
   task automatic send_beat(input logic [63:0] word, input logic [3:0] cnt,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, cnt, word};
      req_tlast  <= last;
      beats_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid straight after the last accepted beat
   task automatic go_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   // sender pause: every tag in, then the round unit given time to go idle
   task automatic wait_drained();
      go_quiet();
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // setup then access phase; the register takes the write at the access edge
   task automatic csr_write(input shk_csr_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // A whole message of random content. Counts on inner words are junk, since
   // the block treats them as full. The last count leans to partial words but
   // also hits the full word and the saturating counts above eight.
   task automatic send_message(input int nwords);
      int r;
      int last_cnt;
      r = $urandom_range(0, 15);
      if (r <= 8)
         last_cnt = r;
      else if (r <= 12)
         last_cnt = 8;
      else
         last_cnt = $urandom_range(9, 15);
      for (int i = 0; i < nwords - 1; i++)
         send_beat({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
      send_beat({$urandom, $urandom}, 4'(last_cnt), 1'b1);
      messages_sent++;
   endtask

   // One register setting: all four registers written while idle, then random
   // messages. Mostly short; a few run past 256 bytes so the length byte wraps.
   task automatic run_phase(input logic [63:0] klo, input logic [63:0] khi,
                            input logic [2:0] crounds, input logic [3:0] frounds,
                            input bit squeeze);
      int start;
      int sel;
      wait_drained();
      csr_write(CSR_KEY_LOW, klo);
      csr_write(CSR_KEY_HIGH, khi);
      csr_write(CSR_CMP_ROUND, {61'd0, crounds});
      csr_write(CSR_FIN_ROUND, {60'd0, frounds});
      settings_run++;
      start = beats_sent;
      if (squeeze) begin
         // receiver holds off while single-word messages keep coming, so the
         // tag register and block queue fill and req_tready drops
         hold_request = 1'b1;
         repeat (40) send_message(1);
      end
      while (beats_sent - start < PHASE_BEATS) begin
         sel = $urandom_range(0, 99);
         if (sel < 70)
            send_message($urandom_range(1, 4));
         else if (sel < 96)
            send_message($urandom_range(5, 12));
         else
            send_message($urandom_range(30, 40));
      end
   endtask

   // --------------------------------------------------------------------------
   // Receiver: its own stall pattern, changing to a random mode of random length,
   // plus the long hold-off on request.
   // --------------------------------------------------------------------------
   initial begin : receiver
      int         hold_left;
      int         mode;
      int         mode_left;
      logic [7:0] pattern;
      hold_left  = 0;
      mode       = 0;
      mode_left  = 0;
      pattern    = 8'hff;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
            pattern   = 8'($urandom);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;                          // no stalls
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 7) == 0);   // heavy stall
               default: begin
                  rsp_tready <= pattern[0];
                  pattern = {pattern[0], pattern[7:1]};
               end
            endcase
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus and verdict
   // --------------------------------------------------------------------------
   initial begin : stimulus
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset key and 2/4 rounds
      // empty message: count zero, junk bits must be masked away
      send_beat(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
      // full last word of all ones: absorbed, then a length-only block
      send_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
      send_beat(64'h0000_0000_0000_0000, 4'd1, 1'b1);
      send_beat(64'h0123_4567_89ab_cdef, 4'd7, 1'b1);
      // counts above eight saturate to a full word
      send_beat(64'ha5a5_5a5a_c3c3_3c3c, 4'd9, 1'b1);
      send_beat(64'h8000_0000_0000_0001, 4'd15, 1'b1);
      // inner words ignore their count, whatever it says
      send_beat(64'hdead_beef_0bad_f00d, 4'd0, 1'b0);
      send_beat(64'hffff_ffff_ffff_ffff, 4'd15, 1'b0);
      send_beat(64'h1122_3344_5566_7788, 4'd3, 1'b1);
      messages_sent += 7;

      // key changed with a message open: the open message keeps the old key,
      // the next one picks up the new key
      send_beat(64'h0f0e_0d0c_0b0a_0908, 4'd2, 1'b0);
      wait_drained();
      csr_write(CSR_KEY_LOW, 64'h0706_0504_0302_0100);
      csr_write(CSR_KEY_HIGH, 64'h0f0e_0d0c_0b0a_0908);
      send_beat(64'h7766_5544_3322_1100, 4'd4, 1'b1);
      send_beat(64'h0000_0000_0403_0201, 4'd5, 1'b1);
      messages_sent += 2;

      // random part, one phase per register setting
      run_phase({$urandom, $urandom}, {$urandom, $urandom}, 3'd1, 4'd3, 1'b0);
      run_phase(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 3'd7, 4'd15, 1'b0);
      run_phase(64'd0, 64'd0, 3'd0, 4'd0, 1'b0);
      run_phase({$urandom, $urandom}, {$urandom, $urandom}, 3'd2, 4'd4, 1'b1);
      run_phase({$urandom, $urandom}, {$urandom, $urandom}, 3'd4, 4'd8, 1'b0);
      run_phase({$urandom, $urandom}, {$urandom, $urandom},
                3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 1'b0);

      wait_drained();
      $display("covered %0d beats in %0d messages over %0d key/round settings",
               beats_sent, messages_sent, settings_run + 1);
      $display("%0d tags compared, %0d mismatches, %0d left waiting",
               tags_checked, failures, pending);
      if (failures == 0 && pending == 0) begin
         $display("tb_siphash_keyed_mac: done, clean");
      end else begin
         $display("tb_siphash_keyed_mac: done, errors");
      end
      $finish;
   end

   // hard stop, well beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("tb_siphash_keyed_mac: done, errors");
      $finish;
   end

endmodule
